// ===== hdl/spza_pkg.sv =====
`timescale 1ns / 1ps
package spza_pkg;

  localparam logic [12:0] COUNT_MAX       = 13'd8191;
  localparam logic [12:0] ZONE_SPAN       = 13'd6304;
  localparam logic [12:0] OUT_LINE_PIXELS = 13'd3200;
  localparam logic [12:0] LINE_PIXELS_RST = 13'd6304;

  // zone bounds on the input side, bases on the output side
  localparam logic [12:0] ZONE1_IN  = 13'd640;
  localparam logic [12:0] ZONE2_IN  = 13'd1376;
  localparam logic [12:0] ZONE3_IN  = 13'd4928;
  localparam logic [12:0] ZONE4_IN  = 13'd5664;
  localparam logic [11:0] ZONE1_OUT = 12'd640;
  localparam logic [11:0] ZONE2_OUT = 12'd1008;
  localparam logic [11:0] ZONE3_OUT = 12'd2192;
  localparam logic [11:0] ZONE4_OUT = 12'd2560;

  localparam logic [31:0] FILL_RADIANCE = 32'h8001_0000;
  localparam logic [7:0]  QUAL_GOOD     = 8'd0;
  localparam logic [7:0]  QUAL_NO_VALID = 8'd2;

  // floor(x/3) = (x * RECIP3) >> RECIP3_SHIFT, exact for x < 4096
  localparam logic [15:0] RECIP3       = 16'd43691;
  localparam int          RECIP3_SHIFT = 17;

  localparam logic [3:0] AGG_SAT_TABLE [4] = '{4'd8, 4'd0, 4'd8, 4'd4};

  // divider: 40-bit dividend, one byte of quotient per step
  localparam int          DIV_BITS  = 40;
  localparam int          DIV_DIGIT = 8;
  localparam logic [2:0]  DIV_LAST  = 3'(DIV_BITS / DIV_DIGIT - 1);

  typedef enum logic [1:0] {
    MODE_PASS_AGG   = 2'd0,
    MODE_PASS       = 2'd1,
    MODE_TRIM       = 2'd2,
    MODE_ZONES      = 2'd3
  } spza_mode_t;

  typedef enum logic [1:0] {
    CFG_MODE        = 2'd0,
    CFG_MARGIN      = 2'd1,
    CFG_LINE_PIXELS = 2'd2
  } spza_cfg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } spza_state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_last;
  } spza_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_valid;
  } spza_sts_t;

endpackage

// ===== hdl/spza_ctrl.sv =====
`timescale 1ns / 1ps
module spza_ctrl
  import spza_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      m_tready,
  input  spza_sts_t sts,
  output spza_cmd_t cmd
);

  spza_state_t state, state_next;
  logic [2:0]  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    s_tready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready   = !sts.out_valid || m_tready;
        cmd.accept = s_tvalid && s_tready;
        if (cmd.accept && sts.need_div) begin
          state_next = ST_DIV;
          step_next  = '0;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (step == DIV_LAST);
        step_next    = step + 3'd1;
        if (cmd.div_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/spza_dpath.sv =====
`timescale 1ns / 1ps
module spza_dpath
  import spza_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic [47:0] s_tdata,
  input  logic [0:0]  s_tuser,
  output logic [63:0] m_tdata,
  output logic        m_tlast,
  input  logic        m_tready,
  input  spza_cmd_t   cmd,
  output spza_sts_t   sts
);

  // configuration
  spza_mode_t  mode;
  logic [7:0]  margin;
  logic [12:0] line_pixels;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PASS_AGG;
      margin      <= '0;
      line_pixels <= LINE_PIXELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:        mode        <= spza_mode_t'(cfg_data[1:0]);
        CFG_MARGIN:      margin      <= cfg_data[7:0];
        CFG_LINE_PIXELS: line_pixels <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word
  logic [31:0] rad;
  logic [7:0]  qual;
  logic        sat, gain_low, line_start;

  assign rad        = s_tdata[31:0];
  assign qual       = s_tdata[39:32];
  assign sat        = s_tdata[40];
  assign gain_low   = s_tdata[41];
  assign line_start = s_tuser[0];

  // line and group state
  logic [12:0] in_cnt;
  logic [33:0] sum;
  logic [1:0]  vcnt;
  logic        seen_unsat, seen_sat;

  logic [12:0] p;
  logic [33:0] sum_base, sum_n;
  logic [1:0]  vcnt_base, vcnt_n;
  logic        su_base, ss_base, su_n, ss_n;

  assign p         = line_start ? '0 : in_cnt;
  assign sum_base  = line_start ? '0 : sum;
  assign vcnt_base = line_start ? '0 : vcnt;
  assign su_base   = line_start ? 1'b0 : seen_unsat;
  assign ss_base   = line_start ? 1'b0 : seen_sat;

  // position decode
  logic        in_range;
  logic [13:0] p_plus_m;
  logic [12:0] r;
  logic [12:0] base_in;
  logic [11:0] base_out;
  logic [1:0]  ag;
  logic [11:0] off;
  logic [27:0] prod3;
  logic [10:0] q3;
  logic [11:0] rem3;
  logic [11:0] grp_q;
  logic [1:0]  grp_pos;
  logic [12:0] idx3;

  assign in_range = p < line_pixels;
  assign p_plus_m = {1'b0, p} + {6'b0, margin};
  assign r        = p - {5'b0, margin};

  always_comb begin
    if (r < ZONE1_IN) begin
      base_in = '0;        base_out = '0;        ag = 2'd1;
    end else if (r < ZONE2_IN) begin
      base_in = ZONE1_IN;  base_out = ZONE1_OUT; ag = 2'd2;
    end else if (r < ZONE3_IN) begin
      base_in = ZONE2_IN;  base_out = ZONE2_OUT; ag = 2'd3;
    end else if (r < ZONE4_IN) begin
      base_in = ZONE3_IN;  base_out = ZONE3_OUT; ag = 2'd2;
    end else begin
      base_in = ZONE4_IN;  base_out = ZONE4_OUT; ag = 2'd1;
    end
  end

  assign off   = 12'(r - base_in);
  assign prod3 = 28'(off) * 28'(RECIP3);
  assign q3    = prod3[27:RECIP3_SHIFT];
  assign rem3  = off - ({1'b0, q3} + {q3, 1'b0});

  always_comb begin
    case (ag)
      2'd2:    begin grp_q = {1'b0, off[11:1]}; grp_pos = {1'b0, off[0]}; end
      2'd3:    begin grp_q = {1'b0, q3};        grp_pos = rem3[1:0];      end
      default: begin grp_q = off;               grp_pos = 2'd0;           end
    endcase
  end

  assign idx3 = 13'(base_out) + 13'(grp_q);

  // accumulation
  logic sample_ok, grp_first, grp_last;

  assign sample_ok = (qual == 8'd0) && (rad != 32'd0) && !rad[31];
  assign grp_first = (grp_pos == 2'd0);
  assign grp_last  = (grp_pos == ag - 2'd1);

  always_comb begin
    sum_n  = grp_first ? '0 : sum_base;
    vcnt_n = grp_first ? '0 : vcnt_base;
    su_n   = grp_first ? 1'b0 : su_base;
    ss_n   = grp_first ? 1'b0 : ss_base;
    if (sample_ok) begin
      sum_n  = sum_n + {2'b0, rad};
      vcnt_n = vcnt_n + 2'd1;
      if (sat) ss_n = 1'b1;
      else     su_n = 1'b1;
    end
  end

  // per-mode result
  logic        emit, need_div, upd_grp;
  logic [31:0] e_rad;
  logic [7:0]  e_q;
  logic [3:0]  e_flags;
  logic [12:0] e_idx;
  logic        e_end;
  logic [3:0]  fold;

  assign fold = {sat, !gain_low, 2'b00};

  always_comb begin
    emit     = 1'b0;
    need_div = 1'b0;
    upd_grp  = 1'b0;
    e_rad    = rad;
    e_q      = qual;
    e_flags  = fold;
    e_idx    = p;
    e_end    = (14'(p) + 14'd1) == {1'b0, line_pixels};
    if (in_range) begin
      case (mode)
        MODE_PASS_AGG: begin
          emit    = 1'b1;
          e_flags = {1'b0, sat, 2'b00};
        end
        MODE_PASS: emit = 1'b1;
        MODE_TRIM: begin
          emit  = (p >= 13'(margin)) && (p_plus_m < {1'b0, line_pixels});
          e_idx = r;
          e_end = (p_plus_m + 14'd1) == {1'b0, line_pixels};
        end
        default: begin
          e_idx = idx3;
          e_end = (idx3 == OUT_LINE_PIXELS - 13'd1);
          if (p >= 13'(margin) && r < ZONE_SPAN) begin
            if (ag == 2'd1) begin
              emit    = 1'b1;
              e_flags = {sat, 3'b000};
            end else begin
              upd_grp = 1'b1;
              e_flags = AGG_SAT_TABLE[{ss_n, su_n}];
              if (grp_last) begin
                if (vcnt_n == 2'd0) begin
                  emit  = 1'b1;
                  e_rad = FILL_RADIANCE;
                  e_q   = QUAL_NO_VALID;
                end else begin
                  need_div = 1'b1;
                end
              end
            end
          end
        end
      endcase
    end
  end

  assign sts.need_div = need_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt     <= '0;
      sum        <= '0;
      vcnt       <= '0;
      seen_unsat <= 1'b0;
      seen_sat   <= 1'b0;
    end else if (cmd.accept) begin
      in_cnt <= (p < COUNT_MAX) ? p + 13'd1 : p;
      if (upd_grp && !grp_last) begin
        sum        <= sum_n;
        vcnt       <= vcnt_n;
        seen_unsat <= su_n;
        seen_sat   <= ss_n;
      end else if (upd_grp || line_start) begin
        sum        <= '0;
        vcnt       <= '0;
        seen_unsat <= 1'b0;
        seen_sat   <= 1'b0;
      end
    end
  end

  // divider, one quotient byte per step
  logic [DIV_BITS-1:0] div_num;
  logic [1:0]          div_d, div_rem, rem_n;
  logic [23:0]         div_quo;
  logic [7:0]          qbyte;
  logic [3:0]          pend_flags;
  logic [12:0]         pend_idx;
  logic                pend_end;

  always_comb begin
    logic [2:0] t;
    rem_n = div_rem;
    qbyte = '0;
    for (int i = DIV_DIGIT - 1; i >= 0; i--) begin
      t = {rem_n, div_num[DIV_BITS - DIV_DIGIT + i]};
      if (t >= {1'b0, div_d}) begin
        rem_n    = 2'(t - {1'b0, div_d});
        qbyte[i] = 1'b1;
      end else begin
        rem_n = t[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && need_div) begin
      div_num    <= {6'b0, sum_n};
      div_d      <= vcnt_n;
      div_rem    <= '0;
      div_quo    <= '0;
      pend_flags <= e_flags;
      pend_idx   <= e_idx;
      pend_end   <= e_end;
    end else if (cmd.div_step) begin
      div_num <= {div_num[DIV_BITS-DIV_DIGIT-1:0], {DIV_DIGIT{1'b0}}};
      div_rem <= rem_n;
      div_quo <= {div_quo[15:0], qbyte};
    end
  end

  // output register
  logic        out_valid;
  logic [31:0] out_rad;
  logic [7:0]  out_q;
  logic [3:0]  out_flags;
  logic [12:0] out_idx;
  logic        out_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && emit) || cmd.div_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_last) begin
      out_rad   <= {div_quo, qbyte};
      out_q     <= QUAL_GOOD;
      out_flags <= pend_flags;
      out_idx   <= pend_idx;
      out_end   <= pend_end;
    end else if (cmd.accept && emit) begin
      out_rad   <= e_rad;
      out_q     <= e_q;
      out_flags <= e_flags;
      out_idx   <= e_idx;
      out_end   <= e_end;
    end
  end

  assign sts.out_valid = out_valid;
  assign m_tdata = {7'b0, out_idx, out_flags, out_q, out_rad};
  assign m_tlast = out_end;

endmodule

// ===== hdl/scan_pixel_zone_aggregator_unit.sv =====
// Channel  Dir  Handshake            Content
// s        in   s_tvalid/s_tready    tdata: pixel word, tuser: line_start
// m        out  m_tvalid/m_tready    tdata: converted pixel, tlast: line_end
// cfg      in   cfg_we               cfg_index selects register, cfg_data value
//
// One word per cycle while the output register drains; the final pixel of a
// 2:1 or 3:1 group with valid samples then goes through the divider (one
// quotient byte per cycle), and s_tready stays low until its result is loaded.
// Synchronous reset: counters and group sums clear, registers take defaults.
// A stalled output holds its word; s_tready stays low until it can be replaced.
`timescale 1ns / 1ps
module scan_pixel_zone_aggregator_unit
  import spza_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // radiance, quality_in, saturated, gain_low
  input  logic [0:0]  s_tuser,   // line_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // radiance_out, quality_out, sat_gain_flags, out_pixel
  output logic        m_tlast
);

  spza_cmd_t cmd;
  spza_sts_t sts;

  spza_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spza_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign m_tvalid = sts.out_valid;

endmodule

// ===== hdl/spza_checker.sv =====
`timescale 1ns / 1ps
module spza_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // no word taken while a stalled result occupies the output register
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted over a stalled result");

  // a new result follows an accept or the end of a divide
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready) || $past(!s_tready))
    else $error("result appeared without a source");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind scan_pixel_zone_aggregator_unit spza_port_checker u_spza_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
